/* rtl/tlbpt_pkg.sv */
// shared types, codes and constants of the tlb page table translator
// no dependencies; used by tlbpt_front, tlbpt_back and the top level
`default_nettype none

package tlbpt_pkg;

	localparam int TLB_ENTRIES_DEF   = 4;
	localparam int TABLE_ENTRIES_DEF = 256;

	localparam int PAGE_W  = 8;
	localparam int VA_W    = 16;
	localparam int ACC_W   = 3;
	localparam int PTE_W   = 13;
	localparam int IN_DW   = 40;
	localparam int OUT_DW  = 32;

	// page table entry layout
	localparam int PTE_VALID_BIT   = 8;
	localparam int PTE_PRESENT_BIT = 9;
	localparam int PTE_PROT_LSB    = 10;

	localparam logic [1:0] FUNC_XLATE = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_INVAL = 2'd2;

	typedef enum logic [1:0] {
		OP_XLATE,
		OP_WRITE,
		OP_INVAL,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT  = 3'd0,
		ST_WALK = 3'd1,
		ST_SEG  = 3'd2,
		ST_PROT = 3'd3,
		ST_DISK = 3'd4,
		ST_DONE = 3'd5
	} status_t;

	typedef enum logic {
		BS_IDLE,
		BS_WALK
	} bstate_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t               op;
		logic [VA_W-1:0]   va;
		logic [ACC_W-1:0]  acc;
		logic [PAGE_W-1:0] tbl_idx;
		logic              tbl_ok;
		logic [PTE_W-1:0]  pte;
	} cmd_t;

	typedef struct packed {
		logic   valid;
		logic   pop;
	} qctl_t;

	typedef struct packed {
		logic [PAGE_W-1:0] disk;
		logic [VA_W-1:0]   phys;
		status_t           status;
	} res_t;

endpackage

`default_nettype wire

/* rtl/tlbpt_front.sv */
// front end: accepts stream transfers, decodes them into commands and queues them
// depends on tlbpt_pkg
`default_nettype none

module tlbpt_front #(
	parameter int TABLE_ENTRIES = tlbpt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [tlbpt_pkg::IN_DW-1:0] s_axis_tdata,
	input  wire logic [1:0]                s_axis_tuser,
	input  wire logic                      q_pop,
	output logic                           q_valid,
	output tlbpt_pkg::cmd_t                q_cmd
);

	tlbpt_pkg::cmd_t  cmd_in;
	tlbpt_pkg::cmd_t  q_mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic [tlbpt_pkg::PAGE_W-1:0] page;

	// decode the transfer into a command
	always_comb begin
		cmd_in.va      = s_axis_tdata[15:0];
		cmd_in.acc     = s_axis_tdata[18:16];
		cmd_in.pte     = {s_axis_tdata[39:37], s_axis_tdata[36], s_axis_tdata[35],
			s_axis_tdata[34:27]};
		page           = s_axis_tdata[15:8];
		case (s_axis_tuser)
			tlbpt_pkg::FUNC_XLATE: begin
				cmd_in.op      = tlbpt_pkg::OP_XLATE;
				cmd_in.tbl_idx = page;
			end
			tlbpt_pkg::FUNC_WRITE: begin
				cmd_in.op      = tlbpt_pkg::OP_WRITE;
				cmd_in.tbl_idx = s_axis_tdata[26:19];
			end
			tlbpt_pkg::FUNC_INVAL: begin
				cmd_in.op      = tlbpt_pkg::OP_INVAL;
				cmd_in.tbl_idx = page;
			end
			default: begin
				cmd_in.op      = tlbpt_pkg::OP_NOP;
				cmd_in.tbl_idx = page;
			end
		endcase
		// index outside the table: translate faults on a tlb miss, write is dropped
		cmd_in.tbl_ok = {1'b0, cmd_in.tbl_idx} < 9'(TABLE_ENTRIES);
	end

	assign s_axis_tready = (count_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != 2'd0);
	assign q_cmd         = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cmd_in;
	end

endmodule

`default_nettype wire

/* rtl/tlbpt_back.sv */
// back end: tlb search, page table store, walk sequencer and result register
// depends on tlbpt_pkg
`default_nettype none

module tlbpt_back #(
	parameter int TLB_ENTRIES   = tlbpt_pkg::TLB_ENTRIES_DEF,
	parameter int TABLE_ENTRIES = tlbpt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire tlbpt_pkg::cmd_t             q_cmd,
	output logic                             q_pop,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [tlbpt_pkg::OUT_DW-1:0]     m_axis_tdata
);

	localparam int PT_AW  = $clog2(TABLE_ENTRIES);
	localparam int TLB_IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

	tlbpt_pkg::bstate_t state_q, state_d;

	logic [TLB_ENTRIES-1:0]           tlb_valid_q;
	logic [tlbpt_pkg::PAGE_W-1:0]     tlb_page_q  [TLB_ENTRIES];
	logic [tlbpt_pkg::PAGE_W-1:0]     tlb_frame_q [TLB_ENTRIES];

	logic [tlbpt_pkg::PTE_W-1:0]      pt_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]         pt_vld_q;
	logic [tlbpt_pkg::PTE_W-1:0]      pte_rd_q;
	logic                             pv_rd_q;

	logic [tlbpt_pkg::VA_W-1:0]       walk_va_q;
	logic [tlbpt_pkg::ACC_W-1:0]      walk_acc_q;

	logic                             out_valid_q;
	tlbpt_pkg::res_t                  res_q, res_d;

	logic                             out_free;
	logic                             res_ld, mem_we, mem_re, hold_ld, fill, inval;
	logic                             hit;
	logic [tlbpt_pkg::PAGE_W-1:0]     hit_frame;
	logic [TLB_IW-1:0]                fill_idx;
	logic [PT_AW-1:0]                 pt_addr;
	logic [tlbpt_pkg::PTE_W-1:0]      pte;
	logic [tlbpt_pkg::PAGE_W-1:0]     pte_frame;
	logic [tlbpt_pkg::ACC_W-1:0]      pte_prot;

	assign out_free = !out_valid_q || m_axis_tready;
	assign pt_addr  = q_cmd.tbl_idx[PT_AW-1:0];
	assign pte       = pv_rd_q ? pte_rd_q : '0;
	assign pte_frame = pte[tlbpt_pkg::PAGE_W-1:0];
	assign pte_prot  = pte[tlbpt_pkg::PTE_PROT_LSB +: tlbpt_pkg::ACC_W];

	// parallel tag compare, lowest matching entry wins
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && tlb_page_q[i] == q_cmd.va[15:8]) begin
				hit       = 1'b1;
				hit_frame = tlb_frame_q[i];
			end
		end
	end

	// first invalid entry, entry 0 when all are in use
	always_comb begin
		fill_idx = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (!tlb_valid_q[i])
				fill_idx = TLB_IW'(i);
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		res_ld  = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		hold_ld = 1'b0;
		fill    = 1'b0;
		inval   = 1'b0;
		res_d   = '{disk: '0, phys: '0, status: tlbpt_pkg::ST_DONE};
		case (state_q)
			tlbpt_pkg::BS_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						tlbpt_pkg::OP_XLATE: begin
							if (hit) begin
								res_ld       = 1'b1;
								res_d.status = tlbpt_pkg::ST_HIT;
								res_d.phys   = {hit_frame, q_cmd.va[7:0]};
							end else if (!q_cmd.tbl_ok) begin
								res_ld       = 1'b1;
								res_d.status = tlbpt_pkg::ST_SEG;
							end else begin
								mem_re  = 1'b1;
								hold_ld = 1'b1;
								state_d = tlbpt_pkg::BS_WALK;
							end
						end
						tlbpt_pkg::OP_WRITE: begin
							res_ld = 1'b1;
							mem_we = q_cmd.tbl_ok;
						end
						tlbpt_pkg::OP_INVAL: begin
							res_ld = 1'b1;
							inval  = 1'b1;
						end
						default: res_ld = 1'b1;
					endcase
				end
			end
			tlbpt_pkg::BS_WALK: begin
				if (out_free) begin
					res_ld  = 1'b1;
					state_d = tlbpt_pkg::BS_IDLE;
					if (!pte[tlbpt_pkg::PTE_VALID_BIT]) begin
						res_d.status = tlbpt_pkg::ST_SEG;
					end else if (!pte[tlbpt_pkg::PTE_PRESENT_BIT]) begin
						res_d.status = tlbpt_pkg::ST_DISK;
						res_d.disk   = pte_frame;
					end else if ((walk_acc_q & ~pte_prot) != '0) begin
						res_d.status = tlbpt_pkg::ST_PROT;
					end else begin
						res_d.status = tlbpt_pkg::ST_WALK;
						res_d.phys   = {pte_frame, walk_va_q[7:0]};
						fill         = 1'b1;
					end
				end
			end
			default: state_d = tlbpt_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlbpt_pkg::BS_IDLE;
			out_valid_q <= 1'b0;
			tlb_valid_q <= '0;
			pt_vld_q    <= '0;
		end else begin
			state_q <= state_d;
			if (res_ld)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (inval)
				tlb_valid_q <= '0;
			else if (fill)
				tlb_valid_q[fill_idx] <= 1'b1;
			if (mem_we)
				pt_vld_q[pt_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld)
			res_q <= res_d;
		if (hold_ld) begin
			walk_va_q  <= q_cmd.va;
			walk_acc_q <= q_cmd.acc;
		end
		if (fill) begin
			tlb_page_q[fill_idx]  <= walk_va_q[15:8];
			tlb_frame_q[fill_idx] <= pte_frame;
		end
	end

	// page table store, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			pt_mem[pt_addr] <= q_cmd.pte;
		if (mem_re) begin
			pte_rd_q <= pt_mem[pt_addr];
			pv_rd_q  <= pt_vld_q[pt_addr];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, res_q.disk, res_q.phys, res_q.status};

endmodule

`default_nettype wire

/* rtl/tlb_page_table_translator.sv */
// tlb page table translator: 16-bit virtual to physical address translation
// input transfer to result: queue register, then result register for tlb hits,
// table writes, tlb invalidates and out-of-range faults; a walk adds the table
// read register; one item per cycle unless the output stalls or a walk is busy
// reset: tlb and page table entries all invalid at once, no clearing pass
// depends on tlbpt_pkg, tlbpt_front, tlbpt_back
`default_nettype none

module tlb_page_table_translator #(
	parameter int TLB_ENTRIES   = tlbpt_pkg::TLB_ENTRIES_DEF,
	parameter int TABLE_ENTRIES = tlbpt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// virt_addr[15:0], access_kind[18:16], entry_index[26:19], entry_frame[34:27],
	// entry_valid[35], entry_present[36], entry_prot[39:37]
	input  wire logic [39:0] s_axis_tdata,
	// func[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// status[2:0], phys_addr[18:3], disk_slot[26:19], zero fill above
	output logic [31:0]      m_axis_tdata
);

	tlbpt_pkg::qctl_t  qctl;
	tlbpt_pkg::cmd_t   q_cmd;

	tlbpt_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_pop        (qctl.pop),
		.q_valid      (qctl.valid),
		.q_cmd        (q_cmd)
	);

	tlbpt_back #(
		.TLB_ENTRIES  (TLB_ENTRIES),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (qctl.valid),
		.q_cmd        (q_cmd),
		.q_pop        (qctl.pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

`ifndef ASSERT_OFF
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> qctl.valid)
		else $error("queue popped while empty");

	a_disk_only_on_disk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != tlbpt_pkg::ST_DISK
		|-> m_axis_tdata[26:19] == 8'd0)
		else $error("disk slot set without on-disk status");

	a_phys_only_translated: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != tlbpt_pkg::ST_HIT
		&& m_axis_tdata[2:0] != tlbpt_pkg::ST_WALK |-> m_axis_tdata[18:3] == 16'd0)
		else $error("physical address set on untranslated result");
`endif

endmodule

`default_nettype wire

/* dv/tb_tlb_page_table_translator.sv */
// testbench for tlb_page_table_translator: directed and random address translation,
// page table writes and tlb invalidates, checked against an in-bench translation model
// depends on tlbpt_pkg and the rtl of tlb_page_table_translator
module tb_tlb_page_table_translator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TLB_N      = 4;
	localparam int TBL_N      = 256;
	localparam int IDLE_LIMIT = 4000;
	localparam int MAX_GAP    = 18;

	typedef struct {
		tlbpt_pkg::op_t func;
		logic [15:0] va;
		logic [2:0]  acc;
		logic [7:0]  idx;
		logic [7:0]  frame;
		logic        valid;
		logic        present;
		logic [2:0]  prot;
	} xlat_req_t;

	typedef struct {
		tlbpt_pkg::status_t status;
		logic [15:0] phys;
		logic [7:0]  disk;
	} xlat_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// translation model state
	logic        tlb_v [TLB_N];
	logic [7:0]  tlb_pg [TLB_N];
	logic [7:0]  tlb_fr [TLB_N];
	logic [12:0] ptab [TBL_N];

	xlat_rsp_t   awaited_rsp[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          tx_no_gap = 0;
	bit          rx_no_stall = 0;
	logic [7:0]  hot_pages [8];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	tlb_page_table_translator #(
		.TLB_ENTRIES  (TLB_N),
		.TABLE_ENTRIES(TBL_N)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata)
	);

	function automatic xlat_rsp_t compute_translation(input xlat_req_t rq);
		xlat_rsp_t   r;
		logic [7:0]  pg;
		logic [7:0]  off;
		logic [12:0] pte;
		bit          hit;
		bit          found;
		int          slot;
		r.status = tlbpt_pkg::ST_DONE;
		r.phys   = '0;
		r.disk   = '0;
		hit      = 0;
		found    = 0;
		slot     = 0;
		case (rq.func)
			tlbpt_pkg::OP_XLATE: begin
				pg  = rq.va[15:8];
				off = rq.va[7:0];
				// lowest matching entry answers, no protection check on a hit
				for (int i = 0; i < TLB_N; i++) begin
					if (!hit && tlb_v[i] && tlb_pg[i] == pg) begin
						hit      = 1;
						r.status = tlbpt_pkg::ST_HIT;
						r.phys   = {tlb_fr[i], off};
					end
				end
				if (!hit) begin
					if (int'(pg) >= TBL_N) begin
						r.status = tlbpt_pkg::ST_SEG;
					end else begin
						pte = ptab[pg];
						if (!pte[tlbpt_pkg::PTE_VALID_BIT]) begin
							r.status = tlbpt_pkg::ST_SEG;
						end else if (!pte[tlbpt_pkg::PTE_PRESENT_BIT]) begin
							r.status = tlbpt_pkg::ST_DISK;
							r.disk   = pte[7:0];
						end else if ((rq.acc & ~pte[tlbpt_pkg::PTE_PROT_LSB +: 3])
								!= 3'b000) begin
							r.status = tlbpt_pkg::ST_PROT;
						end else begin
							for (int i = 0; i < TLB_N; i++) begin
								if (!found && !tlb_v[i]) begin
									found = 1;
									slot  = i;
								end
							end
							tlb_v[slot]  = 1'b1;
							tlb_pg[slot] = pg;
							tlb_fr[slot] = pte[7:0];
							r.status     = tlbpt_pkg::ST_WALK;
							r.phys       = {pte[7:0], off};
						end
					end
				end
			end
			tlbpt_pkg::OP_WRITE: begin
				if (int'(rq.idx) < TBL_N)
					ptab[rq.idx] = {rq.prot, rq.present, rq.valid, rq.frame};
			end
			tlbpt_pkg::OP_INVAL: begin
				for (int i = 0; i < TLB_N; i++)
					tlb_v[i] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// returns at the edge of the transfer; tvalid is left high for a back-to-back follower
	task automatic push_request(input xlat_req_t rq);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rq.func;
		s_tdata  <= {rq.prot, rq.present, rq.valid, rq.frame, rq.idx, rq.acc, rq.va};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		awaited_rsp.push_back(compute_translation(rq));
	endtask

	task automatic drain_answers();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic xlat_req_t random_fill();
		xlat_req_t rq;
		rq.func    = tlbpt_pkg::op_t'($urandom_range(0, 3));
		rq.va      = 16'($urandom());
		rq.acc     = 3'($urandom());
		rq.idx     = 8'($urandom());
		rq.frame   = 8'($urandom());
		rq.valid   = 1'($urandom());
		rq.present = 1'($urandom());
		rq.prot    = 3'($urandom());
		return rq;
	endfunction

	function automatic xlat_req_t mk_write(input logic [7:0] idx, input logic [7:0] frame,
			input logic valid, input logic present, input logic [2:0] prot);
		xlat_req_t rq;
		rq         = random_fill();
		rq.func    = tlbpt_pkg::OP_WRITE;
		rq.idx     = idx;
		rq.frame   = frame;
		rq.valid   = valid;
		rq.present = present;
		rq.prot    = prot;
		return rq;
	endfunction

	function automatic xlat_req_t mk_xlat(input logic [15:0] va, input logic [2:0] acc);
		xlat_req_t rq;
		rq      = random_fill();
		rq.func = tlbpt_pkg::OP_XLATE;
		rq.va   = va;
		rq.acc  = acc;
		return rq;
	endfunction

	// empty table right after reset: every lookup faults
	task automatic test_reset_state();
		push_request(mk_xlat(16'h0000, 3'd0));
		push_request(mk_xlat(16'hffff, 3'd7));
	endtask

	task automatic test_walk_and_hit();
		push_request(mk_write(8'hff, 8'hff, 1'b1, 1'b1, 3'd7));
		push_request(mk_xlat(16'hffff, 3'd7));
		push_request(mk_xlat(16'hff00, 3'd1));
		// table entry revoked, but the cached translation still answers
		push_request(mk_write(8'hff, 8'h00, 1'b0, 1'b0, 3'd0));
		push_request(mk_xlat(16'hff12, 3'd7));
	endtask

	task automatic test_faults();
		push_request(mk_write(8'h02, 8'ha5, 1'b1, 1'b0, 3'd7));
		push_request(mk_xlat(16'h0233, 3'd1));
		push_request(mk_write(8'h03, 8'h5a, 1'b1, 1'b1, 3'd1));
		push_request(mk_xlat(16'h0344, 3'd2));
		// no access bits requested: always allowed
		push_request(mk_xlat(16'h0355, 3'd0));
	endtask

	task automatic test_control_ops();
		xlat_req_t rq;
		rq      = random_fill();
		rq.func = tlbpt_pkg::OP_NOP;
		push_request(rq);
		rq      = random_fill();
		rq.func = tlbpt_pkg::OP_INVAL;
		push_request(rq);
		push_request(mk_xlat(16'hff00, 3'd0));
		push_request(mk_write(8'h00, 8'h00, 1'b1, 1'b1, 3'd0));
		push_request(mk_xlat(16'h0000, 3'd0));
	endtask

	// four live entries, then a miss replaces entry 0
	task automatic test_tlb_replacement();
		for (int p = 0; p < 3; p++)
			push_request(mk_write(8'h10 + 8'(p), 8'h80 + 8'(p), 1'b1, 1'b1, 3'd7));
		push_request(mk_xlat(16'h1001, 3'd3));
		push_request(mk_xlat(16'h1102, 3'd5));
		push_request(mk_xlat(16'h1203, 3'd6));
		push_request(mk_xlat(16'h0304, 3'd1));
		push_request(mk_xlat(16'h1105, 3'd0));
		drain_answers();
	endtask

	task automatic test_random_traffic(input int n_items);
		xlat_req_t rq;
		int        pick;
		for (int i = 0; i < 8; i++)
			hot_pages[i] = 8'($urandom());
		for (int n = 0; n < n_items; n++) begin
			if (n % 64 == 0)
				tx_no_gap = ($urandom_range(0, 3) == 0);
			if (n == n_items / 2)
				drain_answers();
			rq   = random_fill();
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				rq.func = tlbpt_pkg::OP_WRITE;
				if ($urandom_range(0, 9) < 7)
					rq.idx = hot_pages[$urandom_range(0, 7)];
				rq.valid   = ($urandom_range(0, 9) < 8);
				rq.present = ($urandom_range(0, 9) < 8);
			end else if (pick < 92) begin
				rq.func = tlbpt_pkg::OP_XLATE;
				if ($urandom_range(0, 9) < 8)
					rq.va[15:8] = hot_pages[$urandom_range(0, 7)];
				if ($urandom_range(0, 3) == 0)
					rq.acc = 3'd0;
			end else if (pick < 96) begin
				rq.func = tlbpt_pkg::OP_INVAL;
			end else begin
				rq.func = tlbpt_pkg::OP_NOP;
			end
			push_request(rq);
		end
		tx_no_gap = 0;
	endtask

	// result side: random stall before each transfer, checked against the oldest prediction
	initial begin
		xlat_rsp_t want;
		int        stall;
		int        n_rx;
		n_rx = 0;
		@(posedge arst_n);
		forever begin
			if (n_rx % 40 == 0)
				rx_no_stall = ($urandom_range(0, 3) == 0);
			stall = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			n_rx++;
			if (awaited_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result tdata=%h", $realtime, m_tdata);
			end else begin
				want = awaited_rsp.pop_front();
				if (m_tdata[2:0] !== want.status || m_tdata[18:3] !== want.phys ||
						m_tdata[26:19] !== want.disk) begin
					errors++;
					if (errors <= 10)
						$display("%0t: mismatch status/phys/disk exp %0d/%h/%h got %0d/%h/%h",
							$realtime, want.status, want.phys, want.disk,
							m_tdata[2:0], m_tdata[18:3], m_tdata[26:19]);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TLB_N; i++) begin
			tlb_v[i]  = 1'b0;
			tlb_pg[i] = '0;
			tlb_fr[i] = '0;
		end
		for (int i = 0; i < TBL_N; i++)
			ptab[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_walk_and_hit();
		test_faults();
		test_control_ops();
		test_tlb_replacement();
		test_random_traffic(1950);
		drain_answers();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
rtl/tlbpt_pkg.sv
rtl/tlbpt_front.sv
rtl/tlbpt_back.sv
rtl/tlb_page_table_translator.sv
dv/tb_tlb_page_table_translator.sv
